### hw/rtl/cwct_pkg.sv
// Package for the coordinate write-coalescing table.
// Holds command and status codes, field widths, the control/status structs and their enums.
// No dependencies.
`timescale 1ns / 1ps

package cwct_pkg;

  localparam int CMD_W    = 2;
  localparam int COORD_W  = 24;
  localparam int Y_W      = 8;
  localparam int VAL_W    = 16;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int TOTAL_W  = 7;
  localparam int ENTRY_W  = COORD_W + Y_W + COORD_W + VAL_W;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 88;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  // Read address source for the table memory
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_IN_INDEX,
    RD_NEXT
  } rd_src_t;

  // Result to be formed by the datapath
  typedef enum logic [2:0] {
    RES_NONE,
    RES_UPDATE,
    RES_APPEND,
    RES_FULL,
    RES_READ,
    RES_BAD,
    RES_CLEAR
  } res_op_t;

  typedef struct packed {
    logic    load;     // latch the input item, rewind the scan pointer
    rd_src_t rd_src;
    logic    advance;  // step the scan pointer
    res_op_t res_op;
    logic    emit;     // move the result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic match;       // entry under the scan pointer has the item's coordinate
    logic last;        // scan pointer is at the last valid entry
    logic count_zero;
    logic count_full;
    logic index_ok;    // incoming read_index is below the entry count
    logic out_busy;    // output register holds an item not yet taken
  } ctl_sts_t;

endpackage

### hw/rtl/cwct_ctrl.sv
// Controller FSM of the coordinate write-coalescing table.
// Depends on cwct_pkg; drives the command struct of cwct_dp.
`timescale 1ns / 1ps

module cwct_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [cwct_pkg::CMD_W-1:0] in_command,
  input  cwct_pkg::ctl_sts_t       sts,
  output cwct_pkg::ctl_cmd_t       cmd
);
  import cwct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDATA,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.rd_src  = RD_ZERO;
    cmd.advance = 1'b0;
    cmd.res_op  = RES_NONE;
    cmd.emit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.rd_src = (in_command == CMD_READ) ? RD_IN_INDEX : RD_ZERO;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_command)
            CMD_INSERT: begin
              // item registers load at this edge; the append waits for them
              state_nxt = S_SCAN;
            end
            CMD_READ: begin
              if (sts.index_ok) begin
                state_nxt = S_RDATA;
              end else begin
                cmd.res_op = RES_BAD;
                state_nxt  = S_EMIT;
              end
            end
            CMD_CLEAR: begin
              cmd.res_op = RES_CLEAR;
              state_nxt  = S_EMIT;
            end
            default: begin
              cmd.res_op = RES_BAD;
              state_nxt  = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.rd_src = RD_NEXT;
        if (sts.count_zero) begin
          cmd.res_op = RES_APPEND;
          state_nxt  = S_EMIT;
        end else if (sts.match) begin
          cmd.res_op = RES_UPDATE;
          state_nxt  = S_EMIT;
        end else if (sts.last) begin
          cmd.res_op = sts.count_full ? RES_FULL : RES_APPEND;
          state_nxt  = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RDATA: begin
        cmd.res_op = RES_READ;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/cwct_dp.sv
// Datapath of the coordinate write-coalescing table: entry memory, entry
// count, scan pointer, coordinate compare, result and output registers.
// Depends on cwct_pkg; commanded by cwct_ctrl.
`timescale 1ns / 1ps

module cwct_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cwct_pkg::COORD_W-1:0]  in_x,
  input  logic [cwct_pkg::Y_W-1:0]      in_y,
  input  logic [cwct_pkg::COORD_W-1:0]  in_z,
  input  logic [cwct_pkg::VAL_W-1:0]    in_value,
  input  logic [cwct_pkg::IDX_W-1:0]    in_index,
  input  cwct_pkg::ctl_cmd_t            cmd,
  output cwct_pkg::ctl_sts_t            sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [cwct_pkg::OUT_W-1:0]    out_tdata
);
  import cwct_pkg::*;

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int PADW = OUT_W - (STATUS_W + SLOT_W + TOTAL_W + ENTRY_W);

  logic [ENTRY_W-1:0]  mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]  rdata_r;

  logic [COORD_W-1:0]  x_r, z_r;
  logic [Y_W-1:0]      y_r;
  logic [VAL_W-1:0]    v_r;
  logic [IDX_W-1:0]    idx_r;
  logic [AW-1:0]       ptr_r;
  logic [CW-1:0]       count_r, count_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [ENTRY_W-1:0]  res_data_r, res_data_nxt;

  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;

  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic [ENTRY_W-1:0]  item_word;
  logic [AW+IDX_W-1:0] idx_addr_ext;
  logic [AW+SLOT_W-1:0] ptr_slot_ext;
  logic [CW+SLOT_W-1:0] cnt_slot_ext;
  logic [CW+TOTAL_W-1:0] cnt_total_ext;

  // Entry word, lowest bits first: x, y, z, value
  assign item_word     = {v_r, z_r, y_r, x_r};
  assign idx_addr_ext  = {{AW{1'b0}}, in_index};
  assign ptr_slot_ext  = {{SLOT_W{1'b0}}, ptr_r};
  assign cnt_slot_ext  = {{SLOT_W{1'b0}}, count_r};
  assign cnt_total_ext = {{TOTAL_W{1'b0}}, count_r};

  always_comb begin
    case (cmd.rd_src)
      RD_IN_INDEX: rd_addr = idx_addr_ext[AW-1:0];
      RD_NEXT:     rd_addr = ptr_r + AW'(1);
      default:     rd_addr = '0;
    endcase
  end

  assign sts.match      = (rdata_r[COORD_W+Y_W+COORD_W-1:0] == {z_r, y_r, x_r});
  assign sts.last       = ((CW'(ptr_r) + CW'(1)) == count_r);
  assign sts.count_zero = (count_r == '0);
  assign sts.count_full = (count_r == CW'(TABLE_DEPTH));
  assign sts.index_ok   = (CMPW'(in_index) < CMPW'(count_r));
  assign sts.out_busy   = out_valid_r && !out_tready;

  always_comb begin
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_data_nxt   = res_data_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    case (cmd.res_op)
      RES_UPDATE: begin
        wr_en          = 1'b1;
        res_status_nxt = ST_UPDATED;
        res_slot_nxt   = ptr_slot_ext[SLOT_W-1:0];
        res_data_nxt   = '0;
      end
      RES_APPEND: begin
        wr_en          = 1'b1;
        wr_addr        = count_r[AW-1:0];
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_APPENDED;
        res_slot_nxt   = cnt_slot_ext[SLOT_W-1:0];
        res_data_nxt   = '0;
      end
      RES_FULL: begin
        res_status_nxt = ST_FULL;
        res_slot_nxt   = '0;
        res_data_nxt   = '0;
      end
      RES_READ: begin
        res_status_nxt = ST_READ_OK;
        res_slot_nxt   = idx_r;
        res_data_nxt   = rdata_r;
      end
      RES_CLEAR: begin
        count_nxt      = '0;
        res_status_nxt = ST_CLEARED;
        res_slot_nxt   = '0;
        res_data_nxt   = '0;
      end
      RES_BAD: begin
        res_status_nxt = ST_READ_BAD;
        res_slot_nxt   = '0;
        res_data_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_word;
    end
    rdata_r <= mem[rd_addr];
  end

  // Item, scan pointer, result payload and output data registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_x;
      y_r   <= in_y;
      z_r   <= in_z;
      v_r   <= in_value;
      idx_r <= in_index;
      ptr_r <= '0;
    end else if (cmd.advance) begin
      ptr_r <= ptr_r + AW'(1);
    end
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_data_r   <= res_data_nxt;
    if (cmd.emit) begin
      out_data_r <= {{PADW{1'b0}}, res_data_r, cnt_total_ext[TOTAL_W-1:0],
                     res_slot_r, res_status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/coordinate_write_coalescing_table_top.sv
// Top level of the coordinate write-coalescing table.
// Depends on cwct_pkg, cwct_ctrl and cwct_dp.
`timescale 1ns / 1ps

// Table of pending block edits, each an (x, y, z) coordinate with a 16-bit
// value, up to TABLE_DEPTH entries. An insert item scans the valid entries
// in index order, one entry per cycle out of the entry memory's registered
// read port, and overwrites the value of the first entry with the same
// coordinate; without a match it appends at the entry count, or answers
// "full" when the table holds TABLE_DEPTH entries. A read item returns the
// entry at read_index, a clear item empties the table (the stored bits stay,
// only the count drops to zero). Every item gives exactly one result item.
// One item is in work at a time. An insert ends its scan at the matching
// entry, or at the last entry when nothing matches; an insert into an empty
// table appends without comparing an entry, a good read waits for the
// registered read data, and a clear or a bad read forms its result as the
// item is accepted. The result waits in an output register, and the block
// takes the next item while it waits; only the final hand-over stalls until
// the register is free.
// Entries that were never written are never read, so the memory has no
// reset and no clearing pass; the block takes items right after reset.
module coordinate_write_coalescing_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [25:2] coord_x, [33:26] coord_y, [57:34] coord_z,
  // [73:58] block_value, [79:74] read_index
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [8:3] slot, [15:9] entry_total, [39:16] out_x,
  // [47:40] out_y, [71:48] out_z, [87:72] out_value
  output logic [87:0] out_tdata
);
  import cwct_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  cwct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tdata[1:0]),
    .sts        (sts),
    .cmd        (cmd)
  );

  cwct_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_x       (in_tdata[25:2]),
    .in_y       (in_tdata[33:26]),
    .in_z       (in_tdata[57:34]),
    .in_value   (in_tdata[73:58]),
    .in_index   (in_tdata[79:74]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/cwct_chk.sv
// Port-level checker for the coordinate write-coalescing table, bound to the
// top level. Depends on cwct_pkg.
`timescale 1ns / 1ps

module cwct_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);
  import cwct_pkg::*;

  // Held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One item in work at a time: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  // Only a good read carries entry data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != ST_READ_OK) |-> (out_tdata[87:16] == '0))
    else $error("entry data on a result that is not a read");

  // A clear leaves an empty table
  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_CLEARED) |-> (out_tdata[15:9] == '0))
    else $error("entry total not zero after clear");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= ST_CLEARED))
    else $error("undefined status code");

endmodule

bind coordinate_write_coalescing_table_top cwct_chk u_cwct_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
